// ===== src/lli_pkg.sv =====
package lli_pkg;

  // width of the meeting point coordinates
  localparam int OUT_W = 32;

  // saturation limits of the quotient
  localparam logic [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [OUT_W-1:0] coord_out_t;

endpackage

// ===== src/lli_in_if.sv =====
interface lli_in_if #(
  parameter int CW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

// ===== src/lli_out_if.sv =====
interface lli_out_if;
  import lli_pkg::*;
  logic       valid;
  logic       ready;
  coord_out_t meet_x;
  coord_out_t meet_y;
  logic       parallel;
  logic       overflow;

  modport source (output valid, meet_x, meet_y, parallel, overflow, input ready);
  modport sink (input valid, meet_x, meet_y, parallel, overflow, output ready);
endinterface

// ===== src/lli_div_pipe.sv =====
module lli_div_pipe #(
  parameter int NW = 52,
  parameter int DW = 35
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NW-1:0]       num_mag,
  input  logic [DW-1:0]       den_mag,
  input  logic                neg,
  output lli_pkg::coord_out_t quo,
  output logic                ovf
);
  import lli_pkg::*;

  logic [DW-1:0]    rem_r [NW];
  logic [NW-1:0]    num_r [NW];
  logic [DW-1:0]    den_r [NW];
  logic [OUT_W-1:0] q_r   [NW];
  logic             big_r [NW];
  logic             neg_r [NW];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < NW; k++) begin : g_stage
    localparam int I = NW - 1 - k;
    logic [DW-1:0]    rem_in;
    logic [NW-1:0]    num_in;
    logic [DW-1:0]    den_in;
    logic [OUT_W-1:0] q_in;
    logic             big_in;
    logic             neg_in;
    logic [DW:0]      trial_nxt;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_mag;
      assign den_in = den_mag;
      assign q_in   = '0;
      assign big_in = 1'b0;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
      assign big_in = big_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    assign trial_nxt = {rem_in, num_in[NW-1]};
    assign fits      = trial_nxt >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fits ? DW'(trial_nxt - {1'b0, den_in}) : DW'(trial_nxt);
        num_r[k] <= num_in << 1;
        den_r[k] <= den_in;
        neg_r[k] <= neg_in;
      end
    end

    // bits at or above the output width only mark the quotient as too big
    if (I < OUT_W) begin : g_qbit
      always_ff @(posedge clk) begin
        if (en) begin
          q_r[k]   <= q_in | (OUT_W'(fits) << I);
          big_r[k] <= big_in;
        end
      end
    end else begin : g_big
      always_ff @(posedge clk) begin
        if (en) begin
          q_r[k]   <= q_in;
          big_r[k] <= big_in | fits;
        end
      end
    end
  end

  // sign and saturation
  logic [OUT_W-1:0] q_last;
  logic             big_last;
  logic             neg_last;
  logic [OUT_W-1:0] quo_nxt;
  logic             ovf_nxt;
  logic [OUT_W-1:0] quo_r;
  logic             ovf_r;

  assign q_last   = q_r[NW-1];
  assign big_last = big_r[NW-1];
  assign neg_last = neg_r[NW-1];

  always_comb begin
    if (!neg_last) begin
      ovf_nxt = big_last || q_last[OUT_W-1];
      quo_nxt = ovf_nxt ? Q_MAX : q_last;
    end else begin
      ovf_nxt = big_last || (q_last > Q_MIN);
      quo_nxt = ovf_nxt ? Q_MIN : (~q_last + OUT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign quo = coord_out_t'(quo_r);
  assign ovf = ovf_r;
endmodule

// ===== src/line_line_intersection.sv =====
// Meeting point of two lines by Cramer's rule, fully pipelined.
// in_ch carries one item per cycle: two lines, each as start and end point,
// signed fixed point, COORD_BITS wide. out_ch returns one result item per
// input item, in order: meet_x, meet_y (32-bit, same fraction bits as the
// inputs, truncated toward zero and saturated), parallel and overflow.
// Parallel lines report (0,0) with parallel set and overflow clear.
// The pipeline has six stages of line forms, products and magnitudes, then
// a restoring divider with one quotient bit per stage, then a sign and
// saturation stage. Throughput is one item per cycle; the two divider pipes
// run side by side. When the receiver stalls with a result waiting, the
// whole pipeline holds and in_ch.ready drops; nothing is lost or repeated.
// Reset clears the valid bits of all stages, so no result comes out until
// items are accepted.
module line_line_intersection #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lli_in_if.sink    in_ch,
  lli_out_if.source out_ch
);
  import lli_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int AW  = W + 1;
  localparam int PW  = 2 * W + 1;
  localparam int CCW = 2 * W + 2;
  localparam int DW  = 2 * W + 3;
  localparam int MW  = 3 * W + 3;
  localparam int NW  = 3 * W + 4;
  localparam int DL  = NW + 1;

  logic en;
  logic [5:0] v_r;
  logic [DL-1:0] vd_r;
  logic [DL-1:0] pd_r;

  assign en          = !vd_r[DL-1] || out_ch.ready;
  assign in_ch.ready = en;

  // valid bits of the front stages and of the divider span
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vd_r <= '0;
    end else if (en) begin
      v_r  <= {v_r[4:0], in_ch.valid};
      vd_r <= {vd_r[DL-2:0], v_r[5]};
    end
  end

  // stage 1: line coefficients
  logic signed [AW-1:0] a1_r, b1_r, a2_r, b2_r;
  logic signed [W-1:0]  p1x_r, p1y_r, p2x_r, p2y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= AW'(in_ch.first_end_y) - AW'(in_ch.first_start_y);
      b1_r  <= AW'(in_ch.first_start_x) - AW'(in_ch.first_end_x);
      a2_r  <= AW'(in_ch.second_end_y) - AW'(in_ch.second_start_y);
      b2_r  <= AW'(in_ch.second_start_x) - AW'(in_ch.second_end_x);
      p1x_r <= in_ch.first_start_x;
      p1y_r <= in_ch.first_start_y;
      p2x_r <= in_ch.second_start_x;
      p2y_r <= in_ch.second_start_y;
    end
  end

  // stage 2: products for c and the determinant
  logic signed [PW-1:0]  ap1_r, bp1_r, ap2_r, bp2_r;
  logic signed [CCW-1:0] ab12_r, ab21_r;
  logic signed [AW-1:0]  a1_2r, b1_2r, a2_2r, b2_2r;

  always_ff @(posedge clk) begin
    if (en) begin
      ap1_r  <= PW'(a1_r) * PW'(p1x_r);
      bp1_r  <= PW'(b1_r) * PW'(p1y_r);
      ap2_r  <= PW'(a2_r) * PW'(p2x_r);
      bp2_r  <= PW'(b2_r) * PW'(p2y_r);
      ab12_r <= CCW'(a1_r) * CCW'(b2_r);
      ab21_r <= CCW'(a2_r) * CCW'(b1_r);
      a1_2r  <= a1_r;
      b1_2r  <= b1_r;
      a2_2r  <= a2_r;
      b2_2r  <= b2_r;
    end
  end

  // stage 3: c terms and determinant
  logic signed [CCW-1:0] c1_r, c2_r;
  logic signed [DW-1:0]  det_r;
  logic signed [AW-1:0]  a1_3r, b1_3r, a2_3r, b2_3r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= CCW'(ap1_r) + CCW'(bp1_r);
      c2_r  <= CCW'(ap2_r) + CCW'(bp2_r);
      det_r <= DW'(ab12_r) - DW'(ab21_r);
      a1_3r <= a1_2r;
      b1_3r <= b1_2r;
      a2_3r <= a2_2r;
      b2_3r <= b2_2r;
    end
  end

  // stage 4: numerator products
  logic signed [MW-1:0] bc21_r, bc12_r, ac12_r, ac21_r;
  logic signed [DW-1:0] det_4r;

  always_ff @(posedge clk) begin
    if (en) begin
      bc21_r <= MW'(b2_3r) * MW'(c1_r);
      bc12_r <= MW'(b1_3r) * MW'(c2_r);
      ac12_r <= MW'(a1_3r) * MW'(c2_r);
      ac21_r <= MW'(a2_3r) * MW'(c1_r);
      det_4r <= det_r;
    end
  end

  // stage 5: numerators
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [DW-1:0] det_5r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= NW'(bc21_r) - NW'(bc12_r);
      ny_r   <= NW'(ac12_r) - NW'(ac21_r);
      det_5r <= det_4r;
    end
  end

  // stage 6: magnitudes, signs and the parallel test
  logic [NW-1:0] nx_mag_r, ny_mag_r;
  logic [DW-1:0] det_mag_r;
  logic          negx_r, negy_r, par_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_mag_r  <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      ny_mag_r  <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
      det_mag_r <= det_5r[DW-1] ? DW'(-det_5r) : DW'(det_5r);
      negx_r    <= nx_r[NW-1] != det_5r[DW-1];
      negy_r    <= ny_r[NW-1] != det_5r[DW-1];
      par_r     <= det_5r == '0;
    end
  end

  // parallel flag rides beside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      pd_r <= {pd_r[DL-2:0], par_r};
    end
  end

  coord_out_t qx, qy;
  logic       ovfx, ovfy;

  lli_div_pipe #(.NW(NW), .DW(DW)) u_div_x (
    .clk     (clk),
    .en      (en),
    .num_mag (nx_mag_r),
    .den_mag (det_mag_r),
    .neg     (negx_r),
    .quo     (qx),
    .ovf     (ovfx)
  );

  lli_div_pipe #(.NW(NW), .DW(DW)) u_div_y (
    .clk     (clk),
    .en      (en),
    .num_mag (ny_mag_r),
    .den_mag (det_mag_r),
    .neg     (negy_r),
    .quo     (qy),
    .ovf     (ovfy)
  );

  // result item; parallel lines report the origin
  assign out_ch.valid    = vd_r[DL-1];
  assign out_ch.parallel = pd_r[DL-1];
  assign out_ch.meet_x   = pd_r[DL-1] ? '0 : qx;
  assign out_ch.meet_y   = pd_r[DL-1] ? '0 : qy;
  assign out_ch.overflow = !pd_r[DL-1] && (ovfx || ovfy);
endmodule
